[hdl/bsomt_pkg.sv]
`default_nettype none
package bsomt_pkg;

  localparam int unsigned TypeW        = 16;
  localparam int unsigned PriceW       = 16;
  localparam int unsigned HeldW        = 8;
  localparam int unsigned TableDepthDef = 128;

  // one resting order as stored in the table
  typedef struct packed {
    logic [TypeW-1:0]  item_type;
    logic              wanted;
    logic [PriceW-1:0] price;
  } entry_t;

endpackage
`default_nettype wire

[hdl/bsomt_mem.sv]
`default_nettype none
module bsomt_mem #(
  parameter int unsigned Depth = bsomt_pkg::TableDepthDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AddrW-1:0]     waddr_i,
  input  wire bsomt_pkg::entry_t    wdata_i,
  input  wire logic                 re_i,
  input  wire logic [AddrW-1:0]     raddr_i,
  output      bsomt_pkg::entry_t    rdata_o
);
  import bsomt_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[hdl/bsomt_cmp.sv]
`default_nettype none
module bsomt_cmp (
  input  wire bsomt_pkg::entry_t order_i,
  input  wire bsomt_pkg::entry_t rest_i,
  output      logic              hit_o
);
  import bsomt_pkg::*;

  logic [PriceW-1:0] buy_price;
  logic [PriceW-1:0] sell_price;

  // one magnitude comparator, operands swapped by the side of the new order
  always_comb begin
    if (order_i.wanted) begin
      buy_price  = order_i.price;
      sell_price = rest_i.price;
    end else begin
      buy_price  = rest_i.price;
      sell_price = order_i.price;
    end
    hit_o = (order_i.item_type == rest_i.item_type) &&
            (order_i.wanted != rest_i.wanted) &&
            (buy_price >= sell_price);
  end

endmodule
`default_nettype wire

[hdl/buy_sell_order_match_table_unit.sv]
// the order table has a single read port: a request is served by one pipelined scan of the resting
//   orders, then, only when a resting order matched, by one shift pass over the entries after it
// throughput: one request at a time; a result still waiting in the output register holds the
//   request back
// reset clears the order count and the output register; table contents are not cleared
`default_nettype none
module buy_sell_order_match_table_unit #(
  parameter int unsigned TABLE_DEPTH = bsomt_pkg::TableDepthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [bsomt_pkg::TypeW-1:0]   item_type_i,
  input  wire logic                          wanted_i,
  input  wire logic [bsomt_pkg::PriceW-1:0]  price_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic                          matched_o,
  output      logic [bsomt_pkg::TypeW-1:0]   sale_type_o,
  output      logic [bsomt_pkg::PriceW-1:0]  sale_price_o,
  output      logic                          dropped_o,
  output      logic [bsomt_pkg::HeldW-1:0]   entries_held_o
);
  import bsomt_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StShift,
    StFinish
  } state_e;

  state_e            state_q;
  entry_t            ord_q;
  logic [CW-1:0]     count_q;
  logic [CW-1:0]     idx_q;
  logic [CW-1:0]     cmp_idx_q;
  logic              pend_q;
  logic              hit_q;
  logic [PriceW-1:0] hit_price_q;

  logic              out_valid_q;
  logic              matched_q;
  logic [TypeW-1:0]  sale_type_q;
  logic [PriceW-1:0] sale_price_q;
  logic              dropped_q;
  logic [HeldW-1:0]  held_q;

  logic              issue;
  logic              hit;
  logic              full;
  logic              fin_go;
  logic [CW-1:0]     count_d;
  logic [CW-1:0]     wr_idx;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  entry_t            mem_rdata;

  assign issue  = ((state_q == StScan) || (state_q == StShift)) && (idx_q < count_q);
  assign full   = (count_q >= CW'(TABLE_DEPTH));
  assign fin_go = (state_q == StFinish) && (!out_valid_q || out_ready_i);
  assign wr_idx = cmp_idx_q - CW'(1);

  always_comb begin
    if (hit_q) begin
      count_d = count_q - CW'(1);
    end else if (!full) begin
      count_d = count_q + CW'(1);
    end else begin
      count_d = count_q;
    end
  end

  // table writes: shift an entry down by one, or append the new order
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_idx[AW-1:0];
    mem_wdata = mem_rdata;
    case (state_q)
      StShift: begin
        mem_we = pend_q;
      end
      StFinish: begin
        mem_we    = fin_go && !hit_q && !full;
        mem_waddr = count_q[AW-1:0];
        mem_wdata = ord_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  bsomt_mem #(
    .Depth (TABLE_DEPTH),
    .AddrW (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (issue),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  bsomt_cmp u_cmp (
    .order_i (ord_q),
    .rest_i  (mem_rdata),
    .hit_o   (hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      count_q      <= '0;
      idx_q        <= '0;
      cmp_idx_q    <= '0;
      pend_q       <= 1'b0;
      hit_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      ord_q        <= '0;
      hit_price_q  <= '0;
      matched_q    <= 1'b0;
      sale_type_q  <= '0;
      sale_price_q <= '0;
      dropped_q    <= 1'b0;
      held_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !fin_go) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            ord_q   <= '{item_type: item_type_i, wanted: wanted_i, price: price_i};
            idx_q   <= '0;
            pend_q  <= 1'b0;
            hit_q   <= 1'b0;
            state_q <= StScan;
          end
        end
        StScan: begin
          cmp_idx_q <= idx_q;
          if (pend_q && hit) begin
            // drop the read in flight and restart from the entry after the hit
            hit_q       <= 1'b1;
            hit_price_q <= mem_rdata.price;
            idx_q       <= cmp_idx_q + CW'(1);
            pend_q      <= 1'b0;
            state_q     <= StShift;
          end else begin
            pend_q <= issue;
            if (issue) begin
              idx_q <= idx_q + CW'(1);
            end
            if (!pend_q && !issue) begin
              state_q <= StFinish;
            end
          end
        end
        StShift: begin
          pend_q    <= issue;
          cmp_idx_q <= idx_q;
          if (issue) begin
            idx_q <= idx_q + CW'(1);
          end
          if (!pend_q && !issue) begin
            state_q <= StFinish;
          end
        end
        StFinish: begin
          if (fin_go) begin
            out_valid_q  <= 1'b1;
            matched_q    <= hit_q;
            sale_type_q  <= hit_q ? ord_q.item_type : '0;
            sale_price_q <= hit_q ? (ord_q.wanted ? hit_price_q : ord_q.price) : '0;
            dropped_q    <= !hit_q && full;
            held_q       <= HeldW'(count_d);
            count_q      <= count_d;
            state_q      <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_ready_o     = (state_q == StIdle);
  assign out_valid_o    = out_valid_q;
  assign matched_o      = matched_q;
  assign sale_type_o    = sale_type_q;
  assign sale_price_o   = sale_price_q;
  assign dropped_o      = dropped_q;
  assign entries_held_o = held_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("order count above table depth");

  a_match_xor_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(matched_q && dropped_q))
    else $error("result both matched and dropped");

  a_drop_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go && !hit_q && full |=> dropped_q && (count_q == $past(count_q)))
    else $error("drop without full table or count changed");

  a_match_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go && hit_q |=> count_q == $past(count_q) - CW'(1))
    else $error("match did not remove one entry");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && (state_q == StShift) |-> wr_idx < count_q)
    else $error("shift write beyond valid entries");

endmodule
`default_nettype wire
